// ===== rtl/core/peak_to_peak_energy_meter_unit_defines.svh =====
// Assertion macros for the top-level meter file in the core.
`ifndef PEAK_TO_PEAK_ENERGY_METER_UNIT_DEFINES_SVH
`define PEAK_TO_PEAK_ENERGY_METER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on i_clk and disabled while in reset.
`define P2PEM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("p2pem assertion failed");

// Next-cycle implication, clocked on i_clk and disabled while in reset.
`define P2PEM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("p2pem assertion failed");

`endif

// ===== rtl/core/p2pem_pkg.sv =====
package p2pem_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int ENERGY_BITS_DEF = 40;

    localparam int SAMPLE_FIELD_W = 10;
    localparam int IN_DATA_W      = 16;
    localparam int SCALE_W        = 16;
    localparam int CUR_W          = 15;
    localparam int VOLT_W         = 8;
    localparam int POWER_W        = 23;
    localparam int ENERGY_FIELD_W = 40;
    localparam int OUT_DATA_W     = 80;
    localparam int OUT_USER_W     = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_ADDR_W-1:0] REG_SCALE     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CUTOFF    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_OVERCUR   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_VOLTS     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ALARM_THR = 3'd4;

    localparam logic [SCALE_W-1:0]        SCALE_RST     = 16'd26806;
    localparam logic [CUR_W-1:0]          CUTOFF_RST    = 15'd160;
    localparam logic [CUR_W-1:0]          OVERCUR_RST   = 15'd6000;
    localparam logic [VOLT_W-1:0]         VOLTS_RST     = 8'd230;
    localparam logic [ENERGY_FIELD_W-1:0] ALARM_THR_RST = 40'd18000000;

    localparam int                 FRAC_BITS  = 10;
    localparam int                 ROUND_HALF = 512;
    localparam logic [CUR_W-1:0]   CUR_MAX    = 15'd32767;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_status;

endpackage

// ===== rtl/core/p2pem_peak.sv =====
module p2pem_peak #(
    parameter int SAMPLE_BITS = p2pem_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_clear,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0] o_span
);
    import p2pem_pkg::*;

    logic [SAMPLE_BITS-1:0] r_high;
    logic [SAMPLE_BITS-1:0] r_low;
    logic [SAMPLE_BITS-1:0] n_high;
    logic [SAMPLE_BITS-1:0] n_low;

    always_comb begin
        n_high = (i_sample > r_high) ? i_sample : r_high;
        n_low  = (i_sample < r_low) ? i_sample : r_low;
        o_span = (n_high >= n_low) ? (n_high - n_low) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high <= '0;
            r_low  <= '1;
        end else if (i_en) begin
            if (i_clear) begin
                r_high <= '0;
                r_low  <= '1;
            end else begin
                r_high <= n_high;
                r_low  <= n_low;
            end
        end
    end

endmodule

// ===== rtl/core/p2pem_mul.sv =====
module p2pem_mul #(
    parameter int A_W = 16,
    parameter int B_W = 15
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [A_W-1:0]          i_a,
    input  logic [B_W-1:0]          i_b,
    output p2pem_pkg::t_mul_status  o_status,
    output logic [A_W+B_W-1:0]      o_product
);
    import p2pem_pkg::*;

    localparam int PW    = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [PW-1:0]    r_p;
    logic [A_W-1:0]   r_a;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [A_W:0]     n_upper;

    // The multiplier sits in the low bits and retires one bit per step.
    always_comb begin
        n_upper = {1'b0, r_p[PW-1:B_W]} + (r_p[0] ? {1'b0, r_a} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(B_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p <= {{A_W{1'b0}}, i_b};
            r_a <= i_a;
        end else if (r_cnt != '0) begin
            r_p <= {n_upper, r_p[B_W-1:1]};
        end
    end

    assign o_status.busy = (r_cnt != '0);
    assign o_status.done = r_done;
    assign o_product     = r_p;

endmodule

// ===== rtl/core/peak_to_peak_energy_meter_unit.sv =====
// Peak-to-peak current and energy meter. Each input beat carries one ADC sample in tdata
// and tlast marks the last sample of a window; only that beat yields a result beat, which
// carries the current, power and energy totals in tdata and the over-current and one-shot
// energy alarm flags in tuser. A sample without tlast is accepted while the block is idle.
// After a closing sample no new sample is taken until its result beat is registered:
// the bit-serial shift-and-add multiplier retires one bit a cycle and is run twice, once for
// the scaled span and once for the power. The user is to write configuration registers
// through the plain write port while the block is idle; the block does not enforce this.
`include "peak_to_peak_energy_meter_unit_defines.svh"

module peak_to_peak_energy_meter_unit #(
    parameter int SAMPLE_BITS = p2pem_pkg::SAMPLE_BITS_DEF,
    parameter int ENERGY_BITS = p2pem_pkg::ENERGY_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: sample [9:0], zero padding above.
    input  logic [p2pem_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: current_ma [14:0], power_mw [37:15], energy_mj [77:38], zero padding above.
    output logic [p2pem_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: overcurrent [0], energy_alarm [1].
    output logic [p2pem_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [p2pem_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [p2pem_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import p2pem_pkg::*;

    localparam int IN_W   = (SAMPLE_BITS > SAMPLE_FIELD_W) ? SAMPLE_BITS : SAMPLE_FIELD_W;
    localparam int MB_W   = (SAMPLE_BITS > CUR_W) ? SAMPLE_BITS : CUR_W;
    localparam int PW     = SCALE_W + MB_W;
    localparam int SH_W   = PW + 1 - FRAC_BITS;
    localparam int CMP_W  = (ENERGY_BITS > ENERGY_FIELD_W) ? ENERGY_BITS : ENERGY_FIELD_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL1   = 3'd1;
    localparam logic [2:0] ST_SCALE  = 3'd2;
    localparam logic [2:0] ST_MUL2   = 3'd3;
    localparam logic [2:0] ST_ENERGY = 3'd4;
    localparam logic [2:0] ST_ALARM  = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic [SCALE_W-1:0]        r_scale;
    logic [CUR_W-1:0]          r_cutoff;
    logic [CUR_W-1:0]          r_overcur;
    logic [VOLT_W-1:0]         r_volts;
    logic [ENERGY_FIELD_W-1:0] r_alarm_thr;

    logic [CUR_W-1:0]          r_cur;
    logic                      r_over;
    logic [POWER_W-1:0]        r_power;
    logic [ENERGY_BITS-1:0]    r_energy;
    logic                      r_alarm;
    logic                      r_alarm_done;
    logic                      r_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data;
    logic [OUT_USER_W-1:0]     r_out_user;

    logic                      in_accept;
    logic [IN_W-1:0]           sample_ext;
    logic [SAMPLE_BITS-1:0]    span;
    logic                      mul_start;
    logic [SCALE_W-1:0]        mul_a;
    logic [MB_W-1:0]           mul_b;
    t_mul_status               mul_status;
    logic [PW-1:0]             mul_product;
    logic [PW:0]               rounded;
    logic [SH_W-1:0]           shifted;
    logic [CUR_W-1:0]          n_cur;
    logic [ENERGY_BITS:0]      energy_sum;
    logic                      out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign sample_ext    = IN_W'(s_axis_tdata[SAMPLE_FIELD_W-1:0]);
    assign out_free      = !r_out_valid || m_axis_tready;

    p2pem_peak #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_peak (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (in_accept),
        .i_clear  (s_axis_tlast),
        .i_sample (sample_ext[SAMPLE_BITS-1:0]),
        .o_span   (span)
    );

    p2pem_mul #(
        .A_W(SCALE_W),
        .B_W(MB_W)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_status  (mul_status),
        .o_product (mul_product)
    );

    always_comb begin
        rounded = {1'b0, mul_product} + (PW+1)'(ROUND_HALF);
        shifted = rounded[PW:FRAC_BITS];
        n_cur   = (shifted > SH_W'(CUR_MAX)) ? CUR_MAX : shifted[CUR_W-1:0];
        if (n_cur < r_cutoff) begin
            n_cur = '0;
        end
        energy_sum = {1'b0, r_energy} + (ENERGY_BITS+1)'(mul_product[POWER_W-1:0]);
    end

    always_comb begin
        mul_start = 1'b0;
        mul_a     = r_scale;
        mul_b     = MB_W'(span);
        n_state   = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && s_axis_tlast) begin
                    mul_start = 1'b1;
                    n_state   = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (mul_status.done) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                mul_start = 1'b1;
                mul_a     = SCALE_W'(r_volts);
                mul_b     = MB_W'(n_cur);
                n_state   = ST_MUL2;
            end
            ST_MUL2: begin
                if (mul_status.done) begin
                    n_state = ST_ENERGY;
                end
            end
            ST_ENERGY: n_state = ST_ALARM;
            ST_ALARM:  n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_scale      <= SCALE_RST;
            r_cutoff     <= CUTOFF_RST;
            r_overcur    <= OVERCUR_RST;
            r_volts      <= VOLTS_RST;
            r_alarm_thr  <= ALARM_THR_RST;
            r_energy     <= '0;
            r_alarm_done <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SCALE:     r_scale     <= i_cfg_wdata[SCALE_W-1:0];
                    REG_CUTOFF:    r_cutoff    <= i_cfg_wdata[CUR_W-1:0];
                    REG_OVERCUR:   r_overcur   <= i_cfg_wdata[CUR_W-1:0];
                    REG_VOLTS:     r_volts     <= i_cfg_wdata[VOLT_W-1:0];
                    REG_ALARM_THR: r_alarm_thr <= i_cfg_wdata[ENERGY_FIELD_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_ENERGY) begin
                r_energy <= energy_sum[ENERGY_BITS] ? '1 : energy_sum[ENERGY_BITS-1:0];
            end
            if (r_state == ST_ALARM && !r_alarm_done &&
                CMP_W'(r_energy) > CMP_W'(r_alarm_thr)) begin
                r_alarm_done <= 1'b1;
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCALE) begin
            r_cur  <= n_cur;
            r_over <= (n_cur > r_overcur);
        end
        if (r_state == ST_ENERGY) begin
            r_power <= mul_product[POWER_W-1:0];
        end
        if (r_state == ST_ALARM) begin
            r_alarm <= !r_alarm_done && (CMP_W'(r_energy) > CMP_W'(r_alarm_thr));
        end
        if (r_state == ST_OUT && out_free) begin
            r_out_data <= {2'b00, ENERGY_FIELD_W'(r_energy), r_power, r_cur};
            r_out_user <= {r_alarm, r_over};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `P2PEM_ASSERT_IMP(a_mul_busy_in_mul_state, mul_status.busy,
                      r_state == ST_MUL1 || r_state == ST_MUL2)
    `P2PEM_ASSERT_NXT(a_close_starts_mul, in_accept && s_axis_tlast, r_state == ST_MUL1)
    `P2PEM_ASSERT_IMP(a_energy_monotonic, $past(i_rst_n), r_energy >= $past(r_energy))
    `P2PEM_ASSERT_IMP(a_alarm_marks_done, m_axis_tvalid && m_axis_tuser[1], r_alarm_done)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import p2pem_pkg::*;

    localparam logic [SAMPLE_FIELD_W-1:0] SAMPLE_TOP      = '1;
    localparam logic [63:0]               ENERGY_TOP      = (64'd1 << ENERGY_BITS_DEF) - 64'd1;
    localparam logic [CFG_ADDR_W-1:0]     REG_SPARE_FIRST = 3'd5;
    localparam int                        SETTLE_CYCLES   = 48;
    localparam int                        PHASE_SAMPLES   = 180;

    typedef struct packed {
        logic [CUR_W-1:0]          current_ma;
        logic                      overcurrent;
        logic [POWER_W-1:0]        power_mw;
        logic [ENERGY_FIELD_W-1:0] energy_mj;
        logic                      energy_alarm;
    } t_meter_reading;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic                    s_axis_tlast;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic [OUT_USER_W-1:0]   m_axis_tuser;
    logic                    i_cfg_we;
    logic [CFG_ADDR_W-1:0]   i_cfg_addr;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata;

    logic                      idling_on;
    int                        mismatch_count;

    logic [SCALE_W-1:0]        scale_q10;
    logic [CUR_W-1:0]          cutoff_ma;
    logic [CUR_W-1:0]          overcur_ma;
    logic [VOLT_W-1:0]         volts;
    logic [ENERGY_FIELD_W-1:0] alarm_thr_mj;
    logic [SAMPLE_FIELD_W-1:0] high_sample;
    logic [SAMPLE_FIELD_W-1:0] low_sample;
    logic [63:0]               energy_acc;
    logic                      alarm_fired;
    t_meter_reading            pending_readings[$];

    peak_to_peak_energy_meter_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Folds one accepted sample into the peaks and, on a closing sample, queues the reading.
    function automatic void fold_sample(input logic [SAMPLE_FIELD_W-1:0] sample,
                                        input logic closing);
        logic [63:0]    span;
        logic [63:0]    amps;
        logic [63:0]    watts;
        t_meter_reading rd;
        if (sample > high_sample) high_sample = sample;
        if (sample < low_sample) low_sample = sample;
        if (closing) begin
            span = (high_sample >= low_sample) ? 64'(high_sample) - 64'(low_sample) : 64'd0;
            amps = (span * scale_q10 + ROUND_HALF) >> FRAC_BITS;
            if (amps > CUR_MAX) amps = 64'(CUR_MAX);
            if (amps < cutoff_ma) amps = 64'd0;
            watts = volts * amps;
            if (energy_acc > ENERGY_TOP - watts) energy_acc = ENERGY_TOP;
            else energy_acc = energy_acc + watts;
            rd.energy_alarm = 1'b0;
            if (!alarm_fired && energy_acc > alarm_thr_mj) begin
                rd.energy_alarm = 1'b1;
                alarm_fired = 1'b1;
            end
            rd.current_ma  = amps[CUR_W-1:0];
            rd.overcurrent = amps > overcur_ma;
            rd.power_mw    = watts[POWER_W-1:0];
            rd.energy_mj   = energy_acc[ENERGY_FIELD_W-1:0];
            pending_readings.push_back(rd);
            high_sample = '0;
            low_sample  = SAMPLE_TOP;
        end
    endfunction

    task automatic send_sample(input logic [SAMPLE_FIELD_W-1:0] sample, input logic closing);
        int gap;
        @(negedge i_clk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - SAMPLE_FIELD_W){1'b0}}, sample};
        s_axis_tlast  <= closing;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        fold_sample(sample, closing);
    endtask

    task automatic wait_meter_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            REG_SCALE:     scale_q10    = value[SCALE_W-1:0];
            REG_CUTOFF:    cutoff_ma    = value[CUR_W-1:0];
            REG_OVERCUR:   overcur_ma   = value[CUR_W-1:0];
            REG_VOLTS:     volts        = value[VOLT_W-1:0];
            REG_ALARM_THR: alarm_thr_mj = value[ENERGY_FIELD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic test_defaults_after_reset();
        send_sample('0, 1'b0);
        send_sample(SAMPLE_TOP, 1'b1);
        send_sample(10'd512, 1'b1);
        wait_meter_idle();
        write_reg(REG_ALARM_THR, '1);
    endtask

    task automatic test_sample_extremes();
        send_sample(10'h155, 1'b0);
        send_sample(10'h2AA, 1'b1);
        send_sample(SAMPLE_TOP, 1'b1);
    endtask

    task automatic test_rounding_and_saturation();
        wait_meter_idle();
        write_reg(REG_CUTOFF, '0);
        write_reg(REG_SCALE, 40'd512);
        send_sample(10'd700, 1'b0);
        send_sample(10'd701, 1'b1);
        wait_meter_idle();
        write_reg(REG_SCALE, 40'd511);
        send_sample(10'd700, 1'b0);
        send_sample(10'd701, 1'b1);
        wait_meter_idle();
        write_reg(REG_SCALE, 40'hFFFF);
        write_reg(REG_VOLTS, 40'hFF);
        send_sample('0, 1'b0);
        send_sample(SAMPLE_TOP, 1'b1);
    endtask

    task automatic test_cutoff_and_overcurrent();
        int spans[4] = '{99, 100, 200, 201};
        wait_meter_idle();
        write_reg(REG_SCALE, 40'd1024);
        write_reg(REG_CUTOFF, 40'd100);
        write_reg(REG_OVERCUR, 40'd200);
        write_reg(REG_VOLTS, '0);
        foreach (spans[k]) begin
            send_sample(10'd10, 1'b0);
            send_sample(SAMPLE_FIELD_W'(10 + spans[k]), 1'b1);
        end
        wait_meter_idle();
        write_reg(REG_SCALE, 40'hFFFF);
        write_reg(REG_CUTOFF, 40'h7FFF);
        write_reg(REG_OVERCUR, 40'h7FFF);
        write_reg(REG_VOLTS, 40'hFF);
        send_sample('0, 1'b0);
        send_sample(SAMPLE_TOP, 1'b1);
    endtask

    task automatic test_unused_register_index();
        wait_meter_idle();
        for (int a = REG_SPARE_FIRST; a < (1 << CFG_ADDR_W); a++) begin
            write_reg(CFG_ADDR_W'(a), CFG_DATA_W'({$urandom, $urandom}));
        end
        send_sample(SAMPLE_FIELD_W'($urandom_range(0, 1023)), 1'b0);
        send_sample(SAMPLE_FIELD_W'($urandom_range(0, 1023)), 1'b1);
    endtask

    task automatic test_energy_alarm();
        wait_meter_idle();
        write_reg(REG_SCALE, 40'd1024);
        write_reg(REG_CUTOFF, '0);
        write_reg(REG_VOLTS, 40'd255);
        // A span of 100 adds exactly 25500 mJ, so the total lands on the threshold.
        write_reg(REG_ALARM_THR, energy_acc[ENERGY_FIELD_W-1:0] + 40'd25500);
        send_sample(10'd200, 1'b0);
        send_sample(10'd300, 1'b1);
        send_sample(10'd5, 1'b0);
        send_sample(10'd6, 1'b1);
        wait_meter_idle();
        write_reg(REG_ALARM_THR, '0);
        send_sample('0, 1'b0);
        send_sample(SAMPLE_TOP, 1'b1);
    endtask

    task automatic test_random_traffic();
        int                        sent;
        int                        len;
        int                        shape;
        int                        base;
        logic [CFG_DATA_W-1:0]     junk;
        logic [SAMPLE_FIELD_W-1:0] smp;
        for (int phase = 0; phase < 6; phase++) begin
            wait_meter_idle();
            junk = CFG_DATA_W'({$urandom, $urandom});
            case (phase)
                1: begin
                    write_reg(REG_SCALE, {junk[39:16], 16'd0});
                    write_reg(REG_CUTOFF, {junk[39:15], 15'd0});
                    write_reg(REG_OVERCUR, {junk[39:15], 15'd0});
                    write_reg(REG_VOLTS, {junk[39:8], 8'd0});
                    write_reg(REG_ALARM_THR, '0);
                end
                2: begin
                    write_reg(REG_SCALE, {junk[39:16], 16'hFFFF});
                    write_reg(REG_CUTOFF, {junk[39:15], 15'h7FFF});
                    write_reg(REG_OVERCUR, {junk[39:15], 15'h7FFF});
                    write_reg(REG_VOLTS, {junk[39:8], 8'hFF});
                    write_reg(REG_ALARM_THR, '1);
                end
                default: begin
                    write_reg(REG_SCALE, {junk[39:16], 16'($urandom)});
                    write_reg(REG_CUTOFF, {junk[39:15], 15'($urandom_range(0, 3000))});
                    write_reg(REG_OVERCUR, {junk[39:15], 15'($urandom_range(0, 32767))});
                    write_reg(REG_VOLTS, {junk[39:8], 8'($urandom)});
                    write_reg(REG_ALARM_THR, CFG_DATA_W'({$urandom, $urandom}));
                end
            endcase
            sent = 0;
            while (sent < PHASE_SAMPLES) begin
                // The final phase runs without any idling on either side.
                idling_on = (phase < 5) && ($urandom_range(0, 3) != 0);
                shape = $urandom_range(0, 3);
                len = (shape == 3) ? $urandom_range(10, 20) : $urandom_range(1, 9);
                base = $urandom_range(0, 1023 - 40);
                for (int k = 0; k < len; k++) begin
                    case (shape)
                        1: smp = SAMPLE_FIELD_W'(base + $urandom_range(0, 40));
                        2: smp = ($urandom_range(0, 1) != 0) ? SAMPLE_TOP : '0;
                        default: smp = SAMPLE_FIELD_W'($urandom);
                    endcase
                    send_sample(smp, k == len - 1);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 3) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Each result beat is checked against the oldest queued reading.
    always @(posedge i_clk) begin
        t_meter_reading want;
        t_meter_reading got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.current_ma   = m_axis_tdata[CUR_W-1:0];
            got.power_mw     = m_axis_tdata[CUR_W +: POWER_W];
            got.energy_mj    = m_axis_tdata[CUR_W + POWER_W +: ENERGY_FIELD_W];
            got.overcurrent  = m_axis_tuser[0];
            got.energy_alarm = m_axis_tuser[1];
            if (pending_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"unexpected reading: current %0d over %0d power %0d",
                              " energy %0d alarm %0d"},
                             got.current_ma, got.overcurrent, got.power_mw, got.energy_mj,
                             got.energy_alarm);
            end else begin
                want = pending_readings.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"reading mismatch: expected current %0d over %0d",
                                  " power %0d energy %0d alarm %0d, got current %0d",
                                  " over %0d power %0d energy %0d alarm %0d"},
                                 want.current_ma, want.overcurrent, want.power_mw,
                                 want.energy_mj, want.energy_alarm, got.current_ma,
                                 got.overcurrent, got.power_mw, got.energy_mj, got.energy_alarm);
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("FAIL peak_to_peak_energy_meter_unit");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = '0;
        i_cfg_wdata    = '0;
        idling_on      = 1'b1;
        mismatch_count = 0;
        scale_q10      = SCALE_RST;
        cutoff_ma      = CUTOFF_RST;
        overcur_ma     = OVERCUR_RST;
        volts          = VOLTS_RST;
        alarm_thr_mj   = ALARM_THR_RST;
        high_sample    = '0;
        low_sample     = SAMPLE_TOP;
        energy_acc     = '0;
        alarm_fired    = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults_after_reset();
        test_sample_extremes();
        test_rounding_and_saturation();
        test_cutoff_and_overcurrent();
        test_unused_register_index();
        test_energy_alarm();
        test_random_traffic();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        for (int n = 0; n < 2000 && pending_readings.size() != 0; n++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        mismatch_count += pending_readings.size();
        if (mismatch_count == 0)
            $display("PASS peak_to_peak_energy_meter_unit");
        else
            $display("FAIL peak_to_peak_energy_meter_unit");
        $finish;
    end

endmodule
